[rtl/core/assert_macros.svh]
// Assertion macros shared by the list RTL.
// Depends on nothing; the bodies compile away when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define BUVL_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");
`define BUVL_ASSERT_NEVER(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("forbidden condition seen");
`else
`define BUVL_ASSERT(label, clk, rst, prop)
`define BUVL_ASSERT_NEVER(label, clk, rst, expr)
`endif
`endif

[rtl/core/buvl_pkg.sv]
// Types and codes of the bounded unique value list.
// Depends on nothing; used by buvl_cell and the top level.
package buvl_pkg;

   localparam int VALUE_W = 32;

   localparam logic [1:0] OP_INSERT = 2'd0;
   localparam logic [1:0] OP_DELETE = 2'd1;
   localparam logic [1:0] OP_SEARCH = 2'd2;

   typedef enum logic [2:0] {
      ST_OK        = 3'd0,
      ST_PRESENT   = 3'd1,
      ST_FULL      = 3'd2,
      ST_NOT_FOUND = 3'd3,
      ST_EMPTY     = 3'd4
   } status_type;

   typedef struct packed {
      logic insert_en;
      logic delete_en;
   } cell_cmd_type;

endpackage

[rtl/core/buvl_cell.sv]
// One slot of the list: holds a value, compares it, takes a new word or the
// upper neighbor's word. Depends on buvl_pkg.
module buvl_cell #(
   parameter int IDX   = 0,
   parameter int CNT_W = 5,
   parameter int POS_W = 4
) (
   input  logic                                clock,
   input  buvl_pkg::cell_cmd_type              cmd,
   input  logic        [CNT_W-1:0]             count,
   input  logic        [POS_W-1:0]             hit_pos,
   input  logic signed [buvl_pkg::VALUE_W-1:0] value,
   input  logic signed [buvl_pkg::VALUE_W-1:0] upper_data,
   output logic signed [buvl_pkg::VALUE_W-1:0] slot_data,
   output logic                                match
);

   logic signed [buvl_pkg::VALUE_W-1:0] slot_ff;
   logic signed [buvl_pkg::VALUE_W-1:0] slot_in;

   assign slot_data = slot_ff;
   assign match     = (count > CNT_W'(IDX)) && (slot_ff == value);

   always_comb begin
      slot_in = slot_ff;
      if (cmd.insert_en && (count == CNT_W'(IDX))) begin
         slot_in = value;
      end else if (cmd.delete_en && (POS_W'(IDX) >= hit_pos)) begin
         slot_in = upper_data;
      end
   end

   always_ff @(posedge clock) begin
      slot_ff <= slot_in;
   end

endmodule

[rtl/core/bounded_unique_value_list_top.sv]
// Top level of the bounded unique value list: a row of slot cells,
// the fill count and the response register. Depends on buvl_pkg, buvl_cell.
//
//  channel | direction | handshake            | payload
//  req     | in        | req_valid/req_stall  | req_type, req_value
//  rsp     | out       | rsp_valid/rsp_stall  | rsp_status, rsp_position, rsp_fill_count
//
// One request per cycle while req_stall is low; the response is registered and shows in the cycle after acceptance.
// Each cell does one compare per cycle; the hit index and the shift on
// delete are settled in that same cycle.
// Reset clears the fill count and the response valid; slot contents are kept.
// req_stall rises only while a response waits and rsp_stall is high.
`include "assert_macros.svh"
module bounded_unique_value_list_top #(
   parameter int CAPACITY = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic        [1:0]                   req_type,
   input  logic signed [buvl_pkg::VALUE_W-1:0] req_value,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic        [2:0]                   rsp_status,
   output logic        [3:0]                   rsp_position,
   output logic        [4:0]                   rsp_fill_count
);

   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int POS_W = $clog2(CAPACITY);

   logic [CNT_W-1:0] count_ff, count_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [2:0]       rsp_status_ff, rsp_status_in;
   logic [3:0]       rsp_position_ff, rsp_position_in;
   logic [4:0]       rsp_fill_count_ff, rsp_fill_count_in;

   logic                                accept;
   logic                                full;
   logic                                empty;
   logic                                hit_any;
   logic [POS_W-1:0]                    hit_pos;
   logic [CAPACITY-1:0]                 match_vec;
   logic signed [buvl_pkg::VALUE_W-1:0] slot_vec [CAPACITY];
   buvl_pkg::cell_cmd_type              cmd;
   buvl_pkg::status_type                status;

   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;
   assign full      = (count_ff >= CNT_W'(CAPACITY));
   assign empty     = (count_ff == '0);
   assign hit_any   = |match_vec;

   // values are distinct, so at most one cell matches
   always_comb begin
      hit_pos = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         if (match_vec[i]) begin
            hit_pos = hit_pos | POS_W'(i);
         end
      end
   end

   genvar g;
   generate
      for (g = 0; g < CAPACITY; g++) begin : g_cell
         logic signed [buvl_pkg::VALUE_W-1:0] upper;
         if (g == CAPACITY - 1) begin : g_last
            assign upper = slot_vec[g];
         end else begin : g_mid
            assign upper = slot_vec[g+1];
         end
         buvl_cell #(
            .IDX   (g),
            .CNT_W (CNT_W),
            .POS_W (POS_W)
         ) u_cell (
            .clock      (clock),
            .cmd        (cmd),
            .count      (count_ff),
            .hit_pos    (hit_pos),
            .value      (req_value),
            .upper_data (upper),
            .slot_data  (slot_vec[g]),
            .match      (match_vec[g])
         );
      end
   endgenerate

   always_comb begin
      cmd           = '0;
      status        = buvl_pkg::ST_OK;
      rsp_position_in = '0;
      count_in      = count_ff;
      case (req_type)
         buvl_pkg::OP_INSERT: begin
            if (full) begin
               status = buvl_pkg::ST_FULL;
            end else if (hit_any) begin
               status = buvl_pkg::ST_PRESENT;
            end else begin
               cmd.insert_en   = accept;
               rsp_position_in = 4'(count_ff);
               count_in        = count_ff + CNT_W'(1);
            end
         end
         buvl_pkg::OP_DELETE: begin
            if (empty) begin
               status = buvl_pkg::ST_EMPTY;
            end else if (!hit_any) begin
               status = buvl_pkg::ST_NOT_FOUND;
            end else begin
               cmd.delete_en   = accept;
               rsp_position_in = 4'(hit_pos);
               count_in        = count_ff - CNT_W'(1);
            end
         end
         default: begin
            if (hit_any) begin
               rsp_position_in = 4'(hit_pos);
            end else begin
               status = buvl_pkg::ST_NOT_FOUND;
            end
         end
      endcase
      rsp_status_in     = status;
      rsp_fill_count_in = 5'(count_in);
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else begin
         rsp_valid_in = rsp_valid_ff && rsp_stall;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            count_ff <= count_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_status_ff     <= rsp_status_in;
         rsp_position_ff   <= rsp_position_in;
         rsp_fill_count_ff <= rsp_fill_count_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_position   = rsp_position_ff;
   assign rsp_fill_count = rsp_fill_count_ff;

   `BUVL_ASSERT_NEVER(a_count_bound, clock, reset, count_ff > CNT_W'(CAPACITY))
   `BUVL_ASSERT(a_unique_hit, clock, reset, $onehot0(match_vec))
   `BUVL_ASSERT(a_insert_grows, clock, reset, cmd.insert_en |=> count_ff == $past(count_ff) + CNT_W'(1))
   `BUVL_ASSERT(a_delete_shrinks, clock, reset, cmd.delete_en |=> count_ff == $past(count_ff) - CNT_W'(1))

endmodule

[sim/bounded_unique_value_list_top_test.sv]
`timescale 1ns / 1ps
// Self-checking bench for bounded_unique_value_list_top: a directed table, then
// random insert/delete/search traffic scored against a list mirror kept here.
// Depends on buvl_pkg and the list RTL.
module bounded_unique_value_list_top_test;

   localparam int CAPACITY = 16;
   localparam int RANDOM_WORDS = 1600;
   localparam int POOL_SIZE = 24;
   localparam int ROW_COUNT = 25;
   localparam logic [1:0] OP_SPARE = 2'd3;

   typedef struct packed {
      buvl_pkg::status_type status;
      logic [3:0]           position;
      logic [4:0]           fill_count;
   } reply_type;

   typedef struct packed {
      logic [1:0]  op;
      logic [31:0] value;
      logic        typed;
      reply_type   reply;
   } row_type;

   localparam reply_type NO_REPLY = '{buvl_pkg::ST_OK, 4'd0, 5'd0};

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [1:0] req_type = buvl_pkg::OP_SEARCH;
   logic signed [buvl_pkg::VALUE_W-1:0] req_value = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [2:0] rsp_status;
   logic [3:0] rsp_position;
   logic [4:0] rsp_fill_count;

   logic [31:0] mirror_slots [CAPACITY];
   int mirror_count = 0;
   reply_type pending_replies [$];
   bit no_idle = 1'b0;
   int mismatches = 0;
   int replies_checked = 0;
   int op_tally [4] = '{0, 0, 0, 0};
   int full_hits = 0;
   int empty_hits = 0;

   bounded_unique_value_list_top #(.CAPACITY(CAPACITY)) DUT (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_type       (req_type),
      .req_value      (req_value),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_status     (rsp_status),
      .rsp_position   (rsp_position),
      .rsp_fill_count (rsp_fill_count)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // Applies one request to the mirrored list and returns the reply it earns.
   function automatic reply_type apply_request(logic [1:0] op, logic [31:0] v);
      reply_type r;
      int hit;
      int i;
      r = NO_REPLY;
      hit = -1;
      for (i = 0; i < mirror_count; i++) begin
         if (hit < 0 && mirror_slots[i] == v) hit = i;
      end
      case (op)
         buvl_pkg::OP_INSERT: begin
            if (mirror_count >= CAPACITY) r.status = buvl_pkg::ST_FULL;
            else if (hit >= 0) r.status = buvl_pkg::ST_PRESENT;
            else begin
               r.position = 4'(mirror_count);
               mirror_slots[mirror_count] = v;
               mirror_count++;
            end
         end
         buvl_pkg::OP_DELETE: begin
            if (mirror_count == 0) r.status = buvl_pkg::ST_EMPTY;
            else if (hit < 0) r.status = buvl_pkg::ST_NOT_FOUND;
            else begin
               r.position = 4'(hit);
               for (i = hit; i + 1 < mirror_count; i++) mirror_slots[i] = mirror_slots[i + 1];
               mirror_count--;
            end
         end
         default: begin
            if (hit < 0) r.status = buvl_pkg::ST_NOT_FOUND;
            else r.position = 4'(hit);
         end
      endcase
      r.fill_count = 5'(mirror_count);
      return r;
   endfunction

   function automatic int idle_length();
      int roll;
      if (no_idle) return 0;
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      if (roll < 88) return $urandom_range(1, 3);
      if (roll < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   task automatic send_word(logic [1:0] op, logic [31:0] v, logic typed,
                            reply_type typed_reply);
      int gap;
      reply_type predicted;
      gap = idle_length();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_type  <= op;
      req_value <= v;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predicted = apply_request(op, v);
      pending_replies.push_back(typed ? typed_reply : predicted);
      op_tally[op]++;
      if (predicted.status == buvl_pkg::ST_FULL) full_hits++;
      if (predicted.status == buvl_pkg::ST_EMPTY) empty_hits++;
   endtask

   task automatic log_mismatch(string what, reply_type want);
      mismatches++;
      if (mismatches <= 10)
         $display("%0t mismatch (%s): expected status %0d pos %0d fill %0d, got %0d %0d %0d",
                  $time, what, want.status, want.position, want.fill_count,
                  rsp_status, rsp_position, rsp_fill_count);
   endtask

   always @(posedge clock) begin : reply_check
      reply_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_replies.size() == 0) begin
            log_mismatch("nothing outstanding", NO_REPLY);
         end else begin
            want = pending_replies.pop_front();
            replies_checked++;
            if (rsp_status !== want.status || rsp_position !== want.position ||
                rsp_fill_count !== want.fill_count)
               log_mismatch("wrong field", want);
         end
      end
   end

   initial begin : rsp_backpressure
      int run;
      forever begin
         rsp_stall <= 1'b0;
         run = $urandom_range(1, 12);
         if (!no_idle && $urandom_range(0, 7) == 0) run = $urandom_range(40, 120);
         repeat (run) @(posedge clock);
         run = idle_length();
         if (run > 0) begin
            rsp_stall <= 1'b1;
            repeat (run) @(posedge clock);
         end
      end
   end

   initial begin : stimulus
      row_type rows [ROW_COUNT];
      logic [31:0] pool [POOL_SIZE];
      logic [1:0] op;
      logic [31:0] v;
      int roll;
      int n;
      int k;
      bit growing;
      rows = '{
         '{buvl_pkg::OP_SEARCH, 32'h0000_0000, 1'b1, '{buvl_pkg::ST_NOT_FOUND, 4'd0, 5'd0}},
         '{buvl_pkg::OP_DELETE, 32'h0000_0005, 1'b1, '{buvl_pkg::ST_EMPTY, 4'd0, 5'd0}},
         '{buvl_pkg::OP_INSERT, 32'h8000_0000, 1'b1, '{buvl_pkg::ST_OK, 4'd0, 5'd1}},
         '{buvl_pkg::OP_INSERT, 32'h7FFF_FFFF, 1'b1, '{buvl_pkg::ST_OK, 4'd1, 5'd2}},
         '{buvl_pkg::OP_INSERT, 32'h0000_0000, 1'b1, '{buvl_pkg::ST_OK, 4'd2, 5'd3}},
         '{buvl_pkg::OP_INSERT, 32'hFFFF_FFFF, 1'b1, '{buvl_pkg::ST_OK, 4'd3, 5'd4}},
         '{buvl_pkg::OP_INSERT, 32'h7FFF_FFFF, 1'b1, '{buvl_pkg::ST_PRESENT, 4'd0, 5'd4}},
         '{buvl_pkg::OP_INSERT, 32'd1, 1'b0, NO_REPLY},
         '{buvl_pkg::OP_INSERT, 32'd2, 1'b0, NO_REPLY},
         '{buvl_pkg::OP_INSERT, 32'd3, 1'b0, NO_REPLY},
         '{buvl_pkg::OP_INSERT, 32'd4, 1'b0, NO_REPLY},
         '{buvl_pkg::OP_INSERT, 32'd5, 1'b0, NO_REPLY},
         '{buvl_pkg::OP_INSERT, 32'd6, 1'b0, NO_REPLY},
         '{buvl_pkg::OP_INSERT, 32'd7, 1'b0, NO_REPLY},
         '{buvl_pkg::OP_INSERT, 32'd8, 1'b0, NO_REPLY},
         '{buvl_pkg::OP_INSERT, 32'd9, 1'b0, NO_REPLY},
         '{buvl_pkg::OP_INSERT, 32'd10, 1'b0, NO_REPLY},
         '{buvl_pkg::OP_INSERT, 32'd11, 1'b0, NO_REPLY},
         '{buvl_pkg::OP_INSERT, 32'd12, 1'b0, NO_REPLY},
         '{buvl_pkg::OP_INSERT, 32'd13, 1'b1, '{buvl_pkg::ST_FULL, 4'd0, 5'd16}},
         '{buvl_pkg::OP_INSERT, 32'h0000_0000, 1'b1, '{buvl_pkg::ST_FULL, 4'd0, 5'd16}},
         '{buvl_pkg::OP_SEARCH, 32'd12, 1'b0, NO_REPLY},
         '{buvl_pkg::OP_DELETE, 32'h8000_0000, 1'b1, '{buvl_pkg::ST_OK, 4'd0, 5'd15}},
         '{buvl_pkg::OP_DELETE, 32'd12345, 1'b1, '{buvl_pkg::ST_NOT_FOUND, 4'd0, 5'd15}},
         '{OP_SPARE, 32'd12, 1'b0, NO_REPLY}
      };
      pool[0] = 32'h0000_0000;
      pool[1] = 32'hFFFF_FFFF;
      pool[2] = 32'h8000_0000;
      pool[3] = 32'h7FFF_FFFF;
      for (k = 4; k < POOL_SIZE; k++) pool[k] = $urandom;
      growing = 1'b0;

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      for (k = 0; k < ROW_COUNT; k++)
         send_word(rows[k].op, rows[k].value, rows[k].typed, rows[k].reply);

      // alternate fill and drain phases so the list swings between empty and full
      for (n = 0; n < RANDOM_WORDS; n++) begin
         if (n % 40 == 0) begin
            growing = ~growing;
            no_idle = ((n / 40) % 5 == 4);
         end
         roll = $urandom_range(0, 99);
         if (roll < 5) op = OP_SPARE;
         else if (roll < 25) op = buvl_pkg::OP_SEARCH;
         else if (roll < (growing ? 90 : 35)) op = buvl_pkg::OP_INSERT;
         else op = buvl_pkg::OP_DELETE;
         roll = $urandom_range(0, 99);
         if (op != buvl_pkg::OP_INSERT && mirror_count > 0 && roll < 60)
            v = mirror_slots[$urandom_range(0, mirror_count - 1)];
         else if (roll < 80) v = pool[$urandom_range(0, POOL_SIZE - 1)];
         else v = $urandom;
         send_word(op, v, 1'b0, NO_REPLY);
      end
      req_valid <= 1'b0;
      no_idle = 1'b0;

      while (pending_replies.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      $display("requests: %0d insert, %0d delete, %0d search, %0d spare-code search",
               op_tally[buvl_pkg::OP_INSERT], op_tally[buvl_pkg::OP_DELETE],
               op_tally[buvl_pkg::OP_SEARCH], op_tally[OP_SPARE]);
      $display("%0d responses checked; insert on full list %0d times, delete on empty %0d times",
               replies_checked, full_hits, empty_hits);
      if (mismatches == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

   initial begin
      #4000000;
      $display("end of test: mismatches");
      $finish;
   end

endmodule

[bounded_unique_value_list_top.f]
+incdir+rtl/core
rtl/core/buvl_pkg.sv
rtl/core/buvl_cell.sv
rtl/core/bounded_unique_value_list_top.sv
sim/bounded_unique_value_list_top_test.sv
